// File: rtl/srac_pkg.sv
`default_nettype none
package srac_pkg;
   localparam int SLOT_COUNT   = 8;
   localparam int TRACK_COUNT  = 16;
   localparam int BUFFER_BYTES = 65536;
   localparam int SLOT_W  = $clog2(SLOT_COUNT);
   localparam int TRACK_W = $clog2(TRACK_COUNT);
   localparam logic [30:0] RUN_MAX = 31'h7FFF_FFFF;

   typedef enum logic [1:0] {
      OP_READ    = 2'd0,
      OP_DONE    = 2'd1,
      OP_FORGET  = 2'd2,
      OP_RELEASE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ACT_EMPTY   = 3'd0,
      ACT_HIT     = 3'd1,
      ACT_FETCH   = 3'd2,
      ACT_THROUGH = 3'd3,
      ACT_DONE    = 3'd4,
      ACT_MAINT   = 3'd5,
      ACT_REJECT  = 3'd6
   } act_type;

   localparam logic CSR_MAX_SERVED = 1'b0;
   localparam logic CSR_MIN_AHEAD  = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic load;     // capture request
      logic scan;     // search slots and trackers
      logic exec;     // apply update and produce result
   } cmd_type;

   typedef struct packed {
      logic pend_valid;
   } stat_type;

   function automatic logic [30:0] run_add(input logic [30:0] run, input logic [30:0] n);
      logic [31:0] s;
      s = {1'b0, run} + {1'b0, n};
      return s[31] ? RUN_MAX : s[30:0];
   endfunction
endpackage
`default_nettype wire

// File: rtl/srac_ctrl.sv
`default_nettype none
module srac_ctrl
   import srac_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   output cmd_type      cmd,
   output logic         done_strobe
);
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_SCAN;
         ST_SCAN: state_in = ST_EXEC;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign cmd.load    = (state_ff == ST_IDLE) && start;
   assign cmd.scan    = (state_ff == ST_SCAN);
   assign cmd.exec    = (state_ff == ST_EXEC);
   assign done_strobe = cmd.exec;

   a_exec_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |=> cmd.exec) else $error("exec must follow scan");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.scan) else $error("scan must follow load");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scan, cmd.exec})) else $error("commands overlap");
endmodule
`default_nettype wire

// File: rtl/srac_datapath.sv
`default_nettype none
module srac_datapath
   import srac_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_type      cmd,
   input  wire logic         csr_write,
   input  wire logic [0:0]   csr_index,
   input  wire logic [15:0]  csr_data,
   input  wire logic [1:0]   req_op,
   input  wire logic [3:0]   req_thread_id,
   input  wire logic [7:0]   req_file_id,
   input  wire logic [30:0]  req_offset,
   input  wire logic [30:0]  req_request_bytes,
   input  wire logic [30:0]  req_done_bytes,
   output stat_type          stat,
   output logic [2:0]        rsp_action,
   output logic [2:0]        rsp_slot,
   output logic [15:0]       rsp_buffer_offset,
   output logic [30:0]       rsp_length,
   output logic [30:0]       rsp_run_bytes
);
   logic [15:0] max_served_ff, min_ahead_ff;

   logic [3:0]  s_owner_ff [SLOT_COUNT];
   logic [7:0]  s_file_ff  [SLOT_COUNT];
   logic [30:0] s_start_ff [SLOT_COUNT];
   logic [16:0] s_len_ff   [SLOT_COUNT];
   logic [31:0] s_stamp_ff [SLOT_COUNT];
   logic [31:0] clk_ff;
   logic [3:0]  t_owner_ff [TRACK_COUNT];
   logic [7:0]  t_file_ff  [TRACK_COUNT];
   logic [30:0] t_end_ff   [TRACK_COUNT];
   logic [30:0] t_run_ff   [TRACK_COUNT];

   logic        p_valid_ff, p_fetch_ff;
   logic [SLOT_W-1:0] p_slot_ff;
   logic [3:0]  p_thread_ff;
   logic [7:0]  p_file_ff;
   logic [30:0] p_pos_ff, p_want_ff, p_total_ff;

   // captured item
   op_type      op_ff;
   logic [3:0]  me_ff;
   logic [7:0]  f_ff;
   logic [30:0] pos_ff, want_ff, done_ff;

   // scan results (registered)
   logic              hit_ok_ff, hit_fnd_ff, own_fnd_ff, spare_fnd_ff;
   logic [SLOT_W-1:0] hit_ff, old_ff, spare_ff;
   logic              tk_fnd_ff, tk_free_ff;
   logic [TRACK_W-1:0] tk_ff, tk_at_ff;
   logic [30:0]       got_ff, look_ff;

   // scan combinational, keyed on effective thread/file/pos
   logic [3:0]  k_me;
   logic [7:0]  k_f;
   logic [30:0] k_pos;
   logic              hit_fnd, own_fnd, spare_fnd;
   logic [SLOT_W-1:0] hit_i, old_i, spare_i;
   logic              tk_fnd, of_fnd, sp_fnd;
   logic [TRACK_W-1:0] tk_i, of_i, sp_i;
   logic [30:0]       got;

   always_comb begin
      k_me  = (op_ff == OP_DONE) ? p_thread_ff : me_ff;
      k_f   = (op_ff == OP_DONE) ? p_file_ff : f_ff;
      k_pos = (op_ff == OP_DONE) ? p_pos_ff : pos_ff;
      hit_fnd = 1'b0; hit_i = '0; own_fnd = 1'b0; old_i = '0;
      spare_fnd = 1'b0; spare_i = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (s_owner_ff[i] == k_me && s_file_ff[i] == k_f) begin
            hit_fnd = 1'b1; hit_i = SLOT_W'(i);
         end
         if (s_owner_ff[i] == 4'd0) begin
            spare_fnd = 1'b1; spare_i = SLOT_W'(i);
         end
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (s_owner_ff[i] == k_me &&
             (!own_fnd || s_stamp_ff[i] < s_stamp_ff[old_i])) begin
            own_fnd = 1'b1; old_i = SLOT_W'(i);
         end
      end
      tk_fnd = 1'b0; tk_i = '0; of_fnd = 1'b0; of_i = '0; sp_fnd = 1'b0; sp_i = '0;
      for (int i = TRACK_COUNT - 1; i >= 0; i--) begin
         if (t_owner_ff[i] == k_me && t_file_ff[i] == k_f) begin
            tk_fnd = 1'b1; tk_i = TRACK_W'(i);
         end
         if (t_owner_ff[i] == k_me && t_file_ff[i] == 8'd0) begin
            of_fnd = 1'b1; of_i = TRACK_W'(i);
         end
         if (t_owner_ff[i] == 4'd0 && t_owner_ff[i] != k_me) begin
            sp_fnd = 1'b1; sp_i = TRACK_W'(i);
         end
      end
      got = (done_ff > p_total_ff) ? p_total_ff : done_ff;
   end

   // hit range check
   logic [30:0] hdiff;
   logic [31:0] hsum;
   assign hdiff = pos_ff - s_start_ff[hit_i];
   assign hsum  = {1'b0, hdiff} + {1'b0, want_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= op_type'(req_op); me_ff <= req_thread_id; f_ff <= req_file_id;
         pos_ff <= req_offset; want_ff <= req_request_bytes; done_ff <= req_done_bytes;
      end
      if (cmd.scan) begin
         hit_fnd_ff <= hit_fnd; hit_ff <= hit_i; own_fnd_ff <= own_fnd; old_ff <= old_i;
         spare_fnd_ff <= spare_fnd; spare_ff <= spare_i;
         tk_fnd_ff <= tk_fnd; tk_ff <= tk_i;
         tk_free_ff <= of_fnd || sp_fnd; tk_at_ff <= of_fnd ? of_i : sp_i;
         hit_ok_ff <= hit_fnd && want_ff <= {15'd0, max_served_ff} &&
                      pos_ff >= s_start_ff[hit_i] && hsum <= {15'd0, s_len_ff[hit_i]};
         got_ff <= got;
         look_ff <= (tk_fnd && t_end_ff[tk_i] == k_pos) ? run_add(t_run_ff[tk_i], 31'd1)
                                                          : 31'd0;
      end
   end

   // read-ahead amount
   logic [31:0] ahead2, cap, ahead_a;
   always_comb begin
      ahead2 = {look_ff, 1'b0};
      cap = (32'(BUFFER_BYTES) > {16'd0, max_served_ff}) ?
            32'(BUFFER_BYTES) - {16'd0, max_served_ff} : 32'd0;
      ahead_a = (ahead2 < {16'd0, min_ahead_ff}) ? {16'd0, min_ahead_ff} : ahead2;
      if (ahead_a > cap) ahead_a = cap;
   end

   // record_run inputs
   logic        rec;
   logic [30:0] rec_n, rec_val, deliver;
   logic        fetch_go;
   logic [SLOT_W-1:0] fslot;
   always_comb begin
      deliver = got_ff;
      if (p_fetch_ff && got_ff > p_want_ff) deliver = p_want_ff;
      fetch_go = (look_ff != 31'd0) && want_ff <= {15'd0, max_served_ff} &&
                 (own_fnd_ff || spare_fnd_ff);
      fslot = hit_fnd_ff ? hit_ff : (own_fnd_ff ? old_ff : spare_ff);
      rec = 1'b0; rec_n = want_ff;
      if (op_ff == OP_READ && want_ff != 0 && me_ff != 0 && f_ff != 0 && !p_valid_ff
          && hit_ok_ff) rec = 1'b1;
      if (op_ff == OP_DONE && p_valid_ff) begin rec = 1'b1; rec_n = deliver; end
      rec_val = 31'd0;
      if (tk_fnd_ff && t_end_ff[tk_ff] == (op_ff == OP_DONE ? p_pos_ff : pos_ff))
         rec_val = run_add(t_run_ff[tk_ff], rec_n);
   end

   logic [30:0] rec_pos, rec_to;
   assign rec_pos = (op_ff == OP_DONE) ? p_pos_ff : pos_ff;
   assign rec_to  = rec_pos + rec_n;

   // result registers and their next values
   logic [2:0]  rsp_action_ff, rsp_action_in;
   logic [2:0]  rsp_slot_ff, rsp_slot_in;
   logic [15:0] rsp_boff_ff, rsp_boff_in;
   logic [30:0] rsp_length_ff, rsp_length_in;
   logic [30:0] rsp_run_ff, rsp_run_in;

   always_comb begin
      rsp_action_in = ACT_REJECT; rsp_slot_in = '0; rsp_boff_in = '0;
      rsp_length_in = '0; rsp_run_in = '0;
      if (op_ff == OP_READ) begin
         if (want_ff == 31'd0) rsp_action_in = ACT_EMPTY;
         else if (me_ff == 4'd0 || f_ff == 8'd0 || p_valid_ff) rsp_action_in = ACT_REJECT;
         else if (hit_ok_ff) begin
            rsp_action_in = ACT_HIT; rsp_slot_in = 3'(hit_ff);
            rsp_boff_in = hdiff[15:0]; rsp_length_in = want_ff; rsp_run_in = rec_val;
         end else if (fetch_go) begin
            rsp_action_in = ACT_FETCH; rsp_slot_in = 3'(fslot);
            rsp_length_in = want_ff + ahead_a[30:0];
         end else begin
            rsp_action_in = ACT_THROUGH; rsp_length_in = want_ff;
         end
      end else if (op_ff == OP_DONE) begin
         if (p_valid_ff) begin
            rsp_action_in = ACT_DONE;
            if (p_fetch_ff) rsp_slot_in = 3'(p_slot_ff);
            rsp_length_in = deliver; rsp_run_in = rec_val;
         end
      end else begin
         rsp_action_in = ACT_MAINT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_served_ff <= 16'd32768; min_ahead_ff <= 16'd8192;
         clk_ff <= '0; p_valid_ff <= 1'b0; p_fetch_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            s_owner_ff[i] <= '0; s_file_ff[i] <= '0; s_stamp_ff[i] <= '0;
         end
         for (int i = 0; i < TRACK_COUNT; i++) begin
            t_owner_ff[i] <= '0; t_file_ff[i] <= '0;
         end
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_MAX_SERVED: max_served_ff <= csr_data;
               CSR_MIN_AHEAD:  min_ahead_ff  <= csr_data;
               default: ;
            endcase
         end
         if (cmd.exec) begin
            rsp_action_ff <= rsp_action_in; rsp_slot_ff <= rsp_slot_in;
            rsp_boff_ff <= rsp_boff_in; rsp_length_ff <= rsp_length_in;
            rsp_run_ff <= rsp_run_in;
            unique case (op_ff)
               OP_READ: begin
                  if (want_ff != 31'd0 && me_ff != 4'd0 && f_ff != 8'd0 && !p_valid_ff) begin
                     if (hit_ok_ff) begin
                        clk_ff <= clk_ff + 32'd1;
                        s_stamp_ff[hit_ff] <= clk_ff + 32'd1;
                     end else begin
                        p_valid_ff <= 1'b1; p_thread_ff <= me_ff; p_file_ff <= f_ff;
                        p_pos_ff <= pos_ff; p_want_ff <= want_ff;
                        if (fetch_go) begin
                           s_owner_ff[fslot] <= me_ff; s_file_ff[fslot] <= 8'd0;
                           p_fetch_ff <= 1'b1; p_slot_ff <= fslot;
                           p_total_ff <= want_ff + ahead_a[30:0];
                        end else begin
                           p_fetch_ff <= 1'b0; p_slot_ff <= '0; p_total_ff <= want_ff;
                        end
                     end
                  end
               end
               OP_DONE: begin
                  if (p_valid_ff) begin
                     p_valid_ff <= 1'b0;
                     if (p_fetch_ff && got_ff > deliver) begin
                        s_file_ff[p_slot_ff] <= p_file_ff;
                        s_start_ff[p_slot_ff] <= p_pos_ff;
                        s_len_ff[p_slot_ff] <= got_ff[16:0];
                        clk_ff <= clk_ff + 32'd1;
                        s_stamp_ff[p_slot_ff] <= clk_ff + 32'd1;
                     end
                  end
               end
               OP_FORGET: begin
                  for (int i = 0; i < SLOT_COUNT; i++)
                     if (s_file_ff[i] == f_ff) s_file_ff[i] <= 8'd0;
                  for (int i = 0; i < TRACK_COUNT; i++)
                     if (t_file_ff[i] == f_ff) t_file_ff[i] <= 8'd0;
               end
               OP_RELEASE: begin
                  for (int i = 0; i < SLOT_COUNT; i++)
                     if (s_owner_ff[i] == me_ff) begin
                        s_file_ff[i] <= 8'd0; s_owner_ff[i] <= 4'd0;
                     end
                  for (int i = 0; i < TRACK_COUNT; i++)
                     if (t_owner_ff[i] == me_ff) begin
                        t_file_ff[i] <= 8'd0; t_owner_ff[i] <= 4'd0;
                     end
               end
               default: ;
            endcase
            if (rec) begin
               if (tk_fnd_ff) begin
                  t_run_ff[tk_ff] <= rec_val; t_end_ff[tk_ff] <= rec_to;
               end else if (tk_free_ff) begin
                  t_owner_ff[tk_at_ff] <= op_ff == OP_DONE ? p_thread_ff : me_ff;
                  t_file_ff[tk_at_ff] <= op_ff == OP_DONE ? p_file_ff : f_ff;
                  t_end_ff[tk_at_ff] <= rec_to; t_run_ff[tk_at_ff] <= 31'd0;
               end
            end
         end
      end
   end

   assign stat.pend_valid    = p_valid_ff;
   assign rsp_action         = rsp_action_ff;
   assign rsp_slot           = rsp_slot_ff;
   assign rsp_buffer_offset  = rsp_boff_ff;
   assign rsp_length         = rsp_length_ff;
   assign rsp_run_bytes      = rsp_run_ff;

   a_fetch_sets_pend: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && op_ff == OP_READ && hit_ok_ff == 1'b0 && want_ff != 0 && me_ff != 0
      && f_ff != 0 && !p_valid_ff |=> p_valid_ff) else $error("miss must leave a pending record");
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && op_ff == OP_DONE |=> !p_valid_ff) else $error("done must clear pending");
   a_clock_step: assert property (@(posedge clock) disable iff (reset)
      !cmd.exec |=> $stable(clk_ff)) else $error("use clock moved outside exec");
endmodule
`default_nettype wire

// File: rtl/sequential_read_ahead_controller_top.sv
`default_nettype none
// sequential read-ahead controller
// decides for each valid read whether it hits a thread's buffer slot, starts one
// combined fetch (request plus read-ahead) into a slot, or reads through.
// channels:
//   req_*  : one item per transfer, taken when start is high and busy is low
//   rsp_*  : one result per item, flagged by a one-cycle done pulse
//   csr_*  : write port, index 0 max served bytes, index 1 min read-ahead
// sequence: the item is captured, then slots and trackers are searched, then
//   updated; done is registered after the update, and busy is high for the
//   search and update steps, so no new item is taken until the update has
//   finished, set by the three-step sequence in the controller
// reset: synchronous; slots and trackers become unowned, nothing pending,
//   registers return to 32768 and 8192
// the receiver cannot stall: done is a one-cycle strobe with no back-pressure
module sequential_read_ahead_controller_top
   import srac_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_op,
   input  wire logic [3:0]  req_thread_id,
   input  wire logic [7:0]  req_file_id,
   input  wire logic [30:0] req_offset,
   input  wire logic [30:0] req_request_bytes,
   input  wire logic [30:0] req_done_bytes,
   input  wire logic        csr_write,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_data,
   output logic             done,
   output logic [2:0]       rsp_action,
   output logic [2:0]       rsp_slot,
   output logic [15:0]      rsp_buffer_offset,
   output logic [30:0]      rsp_length,
   output logic [30:0]      rsp_run_bytes
);
   cmd_type  cmd;
   stat_type stat;
   logic     strobe;
   logic     done_ff;

   // controller: sequences capture, search and update
   srac_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .cmd(cmd), .done_strobe(strobe)
   );

   // datapath: slot and tracker state, result registers
   srac_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_op(req_op), .req_thread_id(req_thread_id), .req_file_id(req_file_id),
      .req_offset(req_offset), .req_request_bytes(req_request_bytes),
      .req_done_bytes(req_done_bytes), .stat(stat),
      .rsp_action(rsp_action), .rsp_slot(rsp_slot),
      .rsp_buffer_offset(rsp_buffer_offset), .rsp_length(rsp_length),
      .rsp_run_bytes(rsp_run_bytes)
   );

   // result registers load on the update cycle, done is the strobe through a register
   always_ff @(posedge clock) begin
      if (reset) done_ff <= 1'b0;
      else done_ff <= strobe;
   end
   assign done = done_ff;

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("done longer than one cycle");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |-> !busy) else $error("done while still busy");
   a_pend_read_rejected: assert property (@(posedge clock) disable iff (reset)
      done && stat.pend_valid && rsp_action == ACT_HIT |-> 1'b0)
      else $error("hit with a pending record");
endmodule
`default_nettype wire
